### rtl/dq_pkg.sv
// shared codes and controller/datapath interface types for the double-ended queue
`timescale 1ns / 1ps

package dq_pkg;

  // request function codes
  localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FN_PUSH_BACK  = 2'd1;
  localparam logic [1:0] FN_POP_FRONT  = 2'd2;
  localparam logic [1:0] FN_POP_BACK   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // update ring pointers, write or read the store
    logic load;     // move the result into the output register
  } dq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rsp_blocked;  // output register holds a result not yet taken
  } dq_stat_t;

endpackage

### rtl/dq_ctrl.sv
// controller state machine sequencing one transaction at a time
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output dq_pkg::dq_cmd_t cmd,
  input  dq_pkg::dq_stat_t stat
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // request side is open only while idle
  assign req_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!stat.rsp_blocked) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/dq_datapath.sv
// ring store, front index, entry count and output register
`timescale 1ns / 1ps

module dq_datapath #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  dq_pkg::dq_cmd_t     cmd,
  output dq_pkg::dq_stat_t    stat,
  input  logic [1:0]          func,
  input  logic signed [31:0]  push_value,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic signed [31:0]  popped_value,
  output logic [1:0]          status,
  output logic [CW-1:0]       occupancy
);
  import dq_pkg::*;

  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   mem_q;

  logic [1:0]    req_func;
  logic [31:0]   req_value;
  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [1:0]    res_status;
  logic          res_pop_ok;

  logic          is_push;
  logic          full;
  logic          empty;
  logic [AW-1:0] cnt_low;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] last_slot;
  logic [AW-1:0] slot;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count_next;
  logic [1:0]    status_next;
  logic          write_en;

  // add an offset below DEPTH to a slot and wrap into the ring
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  // slot selection and pointer arithmetic
  always_comb begin
    is_push   = ~req_func[1];
    full      = (count == DEPTH_C);
    empty     = (count == '0);
    cnt_low   = count[AW-1:0];
    front_dec = (front == '0) ? LAST : front - 1'b1;
    front_inc = ring(front, AW'(1));
    back_slot = ring(front, cnt_low);
    last_slot = ring(front, cnt_low - 1'b1);

    front_next  = front;
    count_next  = count;
    status_next = ST_DONE;
    write_en    = 1'b0;
    slot        = front;
    case (req_func)
      FN_PUSH_FRONT: begin
        slot = front_dec;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          write_en   = 1'b1;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        slot = back_slot;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          write_en   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        slot = front;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      FN_POP_BACK: begin
        slot = last_slot;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
    // a pop that empties the queue restarts the ring at slot zero
    if (!is_push && !empty && count_next == '0) begin
      front_next = '0;
    end
  end

  // ring store: an optional write and one registered read per transaction
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (write_en) begin
        mem[slot] <= req_value;
      end
      mem_q <= mem[slot];
    end
  end

  // request and result holding registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func  <= func;
      req_value <= push_value;
    end
    if (cmd.exec) begin
      res_status <= status_next;
      res_pop_ok <= !is_push && !empty;
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_value <= res_pop_ok ? mem_q : '0;
      status       <= res_status;
      occupancy    <= count;
    end
  end

  assign stat.rsp_blocked = rsp_valid && rsp_stall;

endmodule

### rtl/double_ended_queue.sv
// top level: bounded double-ended queue in a ring store
// the controller takes one transaction at a time through three steps (capture,
// store access, output load), and the result is then presented from the output
// register; the next request is taken while a result waits, but its load step
// stalls until that result is taken
// reset: front index and entry count clear to zero, store contents undefined until written
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        func,
  input  logic signed [31:0]                push_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic signed [31:0]                popped_value,
  output logic [1:0]                        status,
  output logic [$clog2(DEPTH + 1)-1:0]      occupancy
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // sequencing
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage and arithmetic
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .push_value   (push_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy)
  );

endmodule

### bench/double_ended_queue_tb.sv
// self-checking testbench for the double-ended queue with a driver, a monitor and a predictor
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 626;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 60;

  // one request as the sender offers it
  typedef struct {
    logic [1:0]         fn;
    logic signed [31:0] word;
    int                 gap;
    bit                 drain;
  } deque_req_t;

  // one response as the block should return it
  typedef struct {
    logic signed [31:0] popped;
    logic [1:0]         st;
    logic [OCC_W-1:0]   occ;
  } deque_rsp_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [1:0]               func = FN_PUSH_BACK;
  logic signed [31:0]       push_value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [31:0]       popped_value;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;

  deque_req_t request_queue[$];
  deque_rsp_t expected_results[$];

  // predictor state: ring contents, front slot and entry count
  logic signed [31:0] model_ring [DEPTH];
  int                 model_front = 0;
  int                 model_count = 0;

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_pops = 0;
  int idle_cnt = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func(func),
    .push_value(push_value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .popped_value(popped_value),
    .status(status),
    .occupancy(occupancy)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the predicted deque and queue its response
  task automatic predict_deque_result(input logic [1:0] fn, input logic signed [31:0] word);
    deque_rsp_t r;
    int slot;
    r.popped = '0;
    r.st = ST_DONE;
    if (fn == FN_PUSH_FRONT || fn == FN_PUSH_BACK) begin
      if (model_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        if (fn == FN_PUSH_FRONT) begin
          model_front = (model_front == 0) ? DEPTH - 1 : model_front - 1;
          slot = model_front;
        end else begin
          slot = (model_front + model_count) % DEPTH;
        end
        model_ring[slot] = word;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        if (fn == FN_POP_FRONT) begin
          r.popped = model_ring[model_front];
          model_front = (model_front + 1) % DEPTH;
        end else begin
          r.popped = model_ring[(model_front + model_count - 1) % DEPTH];
        end
        model_count--;
        // an emptied queue restarts at slot zero
        if (model_count == 0) model_front = 0;
      end
    end
    r.occ = model_count[OCC_W-1:0];
    expected_results.push_back(r);
  endtask

  // idle draw with calm stretches where no gaps are taken
  function automatic int draw_wait(input int idx);
    if ((idx / 50) % 4 == 1) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic logic signed [31:0] draw_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh00000000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input logic [1:0] fn, input logic signed [31:0] word,
                             input bit drain);
    deque_req_t q;
    q.fn = fn;
    q.word = word;
    q.gap = draw_wait(request_queue.size());
    q.drain = drain;
    request_queue.push_back(q);
  endtask

  // driver: offers queued requests and predicts each accepted transaction
  always @(posedge clk) begin
    deque_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      func <= FN_PUSH_BACK;
      push_value <= '0;
      idle_cnt = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_deque_result(func, push_value);
        n_sent++;
      end
      if (!req_valid || !req_stall) begin
        if (request_queue.size() == 0) begin
          req_valid <= 1'b0;
        end else if (request_queue[0].drain &&
                     (expected_results.size() != 0 || (rsp_valid && !rsp_stall))) begin
          // hold the sender until every outstanding response is back
          req_valid <= 1'b0;
        end else if (idle_cnt < request_queue[0].gap) begin
          idle_cnt++;
          req_valid <= 1'b0;
        end else begin
          nxt = request_queue.pop_front();
          req_valid <= 1'b1;
          func <= nxt.fn;
          push_value <= nxt.word;
          idle_cnt = 0;
        end
      end
    end
  end

  // monitor: checks each accepted response and drives the receiver stall
  always @(posedge clk) begin
    deque_rsp_t exp_rsp;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_left > 0) hold_left--;
      if (stall_left > 0) stall_left--;
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: response with nothing expected, popped %0d status %0d occupancy %0d",
                   $time, popped_value, status, occupancy);
          errors++;
        end else begin
          exp_rsp = expected_results.pop_front();
          if (popped_value !== exp_rsp.popped) begin
            $display("%0t: popped_value mismatch, expected %0d, actual %0d",
                     $time, exp_rsp.popped, popped_value);
            errors++;
          end
          if (status !== exp_rsp.st) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_rsp.st, status);
            errors++;
          end
          if (occupancy !== exp_rsp.occ) begin
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, exp_rsp.occ, occupancy);
            errors++;
          end
          if (exp_rsp.st == ST_FULL) n_full++;
          if (exp_rsp.st == ST_EMPTY) n_empty++;
          if (exp_rsp.st == ST_DONE && exp_rsp.popped != 0) n_pops++;
        end
        n_checked++;
        stall_left = draw_wait(n_checked);
        // long receiver hold so the block backs up into the sender
        if (n_checked == 200 || n_checked == 480) hold_left = HOLD_CYCLES;
      end
      rsp_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d requests still queued, %0d responses outstanding",
               $time, request_queue.size(), expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int bias;
    logic [1:0] fn;

    // pops on an empty queue
    add_request(FN_POP_FRONT, 32'sh12345678, 1'b0);
    add_request(FN_POP_BACK, -32'sd5, 1'b0);
    // extremes of the word, front push wraps to the last slot, pop that empties
    add_request(FN_PUSH_BACK, 32'sh7fffffff, 1'b0);
    add_request(FN_PUSH_FRONT, 32'sh80000000, 1'b0);
    add_request(FN_POP_BACK, 32'sh0, 1'b0);
    add_request(FN_POP_FRONT, -32'sd1, 1'b0);
    // fill to the top from both ends, then push on a full queue
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: add_request(FN_PUSH_FRONT, 32'sh00000000, 1'b0);
        1: add_request(FN_PUSH_BACK, -32'sd1, 1'b0);
        2: add_request(FN_PUSH_FRONT, 32'sh55555555, 1'b0);
        default: add_request(FN_PUSH_BACK, 32'shaaaaaaaa, 1'b0);
      endcase
    end
    add_request(FN_PUSH_FRONT, 32'sh0badf00d, 1'b0);
    add_request(FN_PUSH_BACK, 32'sh7fffffff, 1'b0);

    // random part in bursts that lean toward filling, toward draining or neither
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 85;
          1: bias = 15;
          default: bias = 50;
        endcase
      end
      if ($urandom_range(0, 99) < bias)
        fn = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      else
        fn = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
      add_request(fn, draw_word(), (i == 0 || i == 300 || i == 560));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || req_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected responses never arrived", $time, expected_results.size());
      errors++;
    end
    $display("covered %0d requests and %0d responses: %0d pops with data, %0d full drops,",
             n_sent, n_checked, n_pops, n_full);
    $display("%0d empty pops, random gaps on both sides, two long receiver holds, three drains",
             n_empty);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
